@@ sv/thd_pkg.sv @@
// Shared constants, codes and types of the threshold and 2x2 dilation unit.
`default_nettype none

package thd_pkg;

  // Image geometry limits
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  // Field widths fixed by the register and stream definitions
  localparam int PIX_W      = 8;
  localparam int CFG_DIM_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Counter width: large enough for the geometry limits and the register fields
  localparam int LIM_W = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                         $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W = (LIM_W > CFG_DIM_W) ? LIM_W : CFG_DIM_W;

  // Line store address width
  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // Output queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Beats produced per item at most
  localparam int RES_CNT_W = 2;

  // Pixel levels
  localparam logic [PIX_W-1:0] PIX_SET   = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_CLEAR = {PIX_W{1'b0}};

  // Register reset values
  localparam logic [PIX_W-1:0]     THRESHOLD_RST = PIX_W'(128);
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST     = CFG_DIM_W'(512);
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST    = CFG_DIM_W'(512);
  localparam logic                 DILATE_RST    = 1'b1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2,
    REG_DILATE_ENABLE = 2'd3
  } cfg_reg_e;

  // Input beat kinds
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Binarized bits of one column of the window
  typedef struct packed {
    logic top;
    logic bot;
  } col_bits_t;

  // Controls of a window column cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // One result beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             eoi;
  } result_t;

  // Push controls of the output queue
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Item flags carried down the pipeline
  typedef struct packed {
    logic pix;        // pixel processed, window advances
    logic emit_win;   // window result for the previous column
    logic emit_last;  // last-column result, binarized only
    logic drain;      // drained last-row pixel
    logic eoi;        // final drained pixel of the image
    logic bit_in;     // binarized value of the incoming pixel
  } item_ctl_t;

endpackage

`default_nettype wire

@@ sv/thd_ram.sv @@
// Generic single-port RAM with read-first registered read.
`default_nettype none

module thd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read old contents, then write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/thd_col_cell.sv @@
// One column cell of the 2x2 window: holds a top and bottom bit, hands them on.
`default_nettype none

module thd_col_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire thd_pkg::cell_ctrl_t   ctrl_i,
  input  wire thd_pkg::col_bits_t    bits_i,
  output thd_pkg::col_bits_t         bits_o
);

  thd_pkg::col_bits_t bits_q, bits_d;

  // Clear at end of image, load the neighbor's bits when the window advances
  always_comb begin
    bits_d = bits_q;
    if (ctrl_i.clear) begin
      bits_d = '0;
    end else if (ctrl_i.shift) begin
      bits_d = bits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

  assign bits_o = bits_q;

endmodule

`default_nettype wire

@@ sv/thd_out_fifo.sv @@
// Output queue: takes up to two result beats a cycle, gives one beat a cycle while ready_i is high.
`default_nettype none

module thd_out_fifo (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire thd_pkg::push_t                      push_i,
  input  wire thd_pkg::result_t                    data0_i,
  input  wire thd_pkg::result_t                    data1_i,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output thd_pkg::result_t                         data_o,
  output logic [thd_pkg::FIFO_CNT_W-1:0]           count_o
);

  thd_pkg::result_t                  mem_q [thd_pkg::FIFO_DEPTH];
  logic [thd_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [thd_pkg::FIFO_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [thd_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic [thd_pkg::FIFO_PTR_W-1:0]    wr_ptr_nxt;
  logic [thd_pkg::FIFO_CNT_W-1:0]    n_push;
  logic                              pop;

  assign pop        = (cnt_q != '0) && ready_i;
  assign wr_ptr_nxt = wr_ptr_q + thd_pkg::FIFO_PTR_W'(1);
  assign n_push     = thd_pkg::FIFO_CNT_W'(push_i.first) +
                      thd_pkg::FIFO_CNT_W'(push_i.second);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + thd_pkg::FIFO_PTR_W'(n_push);
    rd_ptr_d = pop ? rd_ptr_q + thd_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + n_push - thd_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed beats; the second follows the first
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.first && push_i.second) begin
      mem_q[wr_ptr_nxt] <= data1_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

@@ sv/threshold_dilate_2x2_unit.sv @@
// Top level of the streaming threshold and 2x2 dilation unit.
// Grey pixels enter in raster order as beats with tuser low; each is binarized
// against the threshold and, with dilation on, ORed over the 2x2 window to its
// lower right. Results leave one row and one pixel behind the input, so after
// the last pixel of an image the user sends one drain beat (tuser high) per
// pixel of the last row; the final drained beat carries tlast. The unit takes
// one beat per clock while s_axis_tready is high: the line store is a
// single-port RAM of MAX_WIDTH bits with one access per beat, followed by a
// chain of two window column cells. A beat's results pass the stage 2 and
// stage 3 flag registers, then enter the output queue. The last column of
// each row after the first gives two result beats when the width exceeds one;
// s_axis_tready drops when queued and in-flight beats leave no room for two
// more. The line store needs no clearing pass after reset. Configuration
// writes are taken at once; write them only while no beat is in flight.
`default_nettype none

module threshold_dilate_2x2_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [thd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [thd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [thd_pkg::PIX_W-1:0]        s_axis_tdata,   // [7:0] in_pixel
  input  wire logic                             s_axis_tuser,   // [0] opcode
  // Output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [thd_pkg::PIX_W-1:0]             m_axis_tdata,   // [7:0] out_pixel
  output logic                                  m_axis_tlast    // end_of_image
);

  localparam int DW = thd_pkg::DIM_W;
  localparam int AW = thd_pkg::ADDR_W;
  localparam int SW = thd_pkg::FIFO_CNT_W + 1;

  // Configuration registers
  logic [thd_pkg::PIX_W-1:0]     thr_q;
  logic [thd_pkg::CFG_DIM_W-1:0] width_q, height_q;
  logic                          dil_q;

  // Raster counters
  logic [DW-1:0] col_q, col_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] drain_q, drain_d;

  // Stage 1 signals
  logic [DW-1:0] w_eff, h_eff, c0, r0, col_inc, d_cl;
  logic          accept, wrap, is_drain, proc, drain_ok, drain_last, pix_bit;
  thd_pkg::item_ctl_t ctl;

  // Line store port
  logic          ram_en, ram_we, ram_rdata;
  logic [AW-1:0] ram_addr;

  // Pipeline flags
  thd_pkg::item_ctl_t s2_q, s3_q;
  logic               s3_bit_q;

  // Window cells
  thd_pkg::cell_ctrl_t cell_ctrl;
  thd_pkg::col_bits_t  cell0_in, cur_col, prev_col;

  // Output queue
  thd_pkg::push_t                  push;
  thd_pkg::result_t                res0, res1, res_out;
  logic [thd_pkg::FIFO_CNT_W-1:0]  fifo_cnt;
  logic                            win_bit;
  logic [SW-1:0]                   n_s2, n_s3, load;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= thd_pkg::THRESHOLD_RST;
      width_q  <= thd_pkg::WIDTH_RST;
      height_q <= thd_pkg::HEIGHT_RST;
      dil_q    <= thd_pkg::DILATE_RST;
    end else if (cfg_valid_i) begin
      case (thd_pkg::cfg_reg_e'(cfg_index_i))
        thd_pkg::REG_THRESHOLD:     thr_q    <= cfg_data_i[thd_pkg::PIX_W-1:0];
        thd_pkg::REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[thd_pkg::CFG_DIM_W-1:0];
        thd_pkg::REG_IMAGE_HEIGHT:  height_q <= cfg_data_i[thd_pkg::CFG_DIM_W-1:0];
        thd_pkg::REG_DILATE_ENABLE: dil_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp geometry into the supported range
  always_comb begin
    w_eff = DW'(width_q);
    if (width_q == '0) begin
      w_eff = DW'(1);
    end else if (DW'(width_q) > DW'(thd_pkg::MAX_WIDTH)) begin
      w_eff = DW'(thd_pkg::MAX_WIDTH);
    end
    h_eff = DW'(height_q);
    if (height_q == '0) begin
      h_eff = DW'(1);
    end else if (DW'(height_q) > DW'(thd_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(thd_pkg::MAX_HEIGHT);
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // Stage 1: position the beat in the raster, address the line store
  always_comb begin
    wrap       = (col_q >= w_eff);
    c0         = wrap ? '0 : col_q;
    r0         = (wrap && (row_q < h_eff)) ? row_q + DW'(1) : row_q;
    is_drain   = (thd_pkg::op_e'(s_axis_tuser) == thd_pkg::OP_DRAIN);
    proc       = !is_drain && (r0 < h_eff) && (c0 < DW'(thd_pkg::MAX_WIDTH));
    pix_bit    = (s_axis_tdata >= thr_q);
    col_inc    = c0 + DW'(1);
    d_cl       = (drain_q >= DW'(thd_pkg::MAX_WIDTH)) ?
                 DW'(thd_pkg::MAX_WIDTH - 1) : drain_q;
    drain_ok   = is_drain && (r0 >= h_eff);
    drain_last = (d_cl >= w_eff - DW'(1));

    ctl.pix       = proc;
    ctl.emit_win  = proc && (r0 != '0) && (c0 != '0);
    ctl.emit_last = proc && (r0 != '0) && (c0 == w_eff - DW'(1));
    ctl.drain     = drain_ok;
    ctl.eoi       = drain_ok && drain_last;
    ctl.bit_in    = pix_bit;

    ram_en   = accept && (proc || drain_ok);
    ram_we   = accept && proc;
    ram_addr = proc ? c0[AW-1:0] : d_cl[AW-1:0];
  end

  // Advance the raster counters
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (accept) begin
      col_d = c0;
      row_d = r0;
      if (proc) begin
        if (col_inc >= w_eff) begin
          col_d = '0;
          row_d = r0 + DW'(1);
        end else begin
          col_d = col_inc;
        end
      end
      if (drain_ok) begin
        if (drain_last) begin
          drain_d = '0;
          col_d   = '0;
          row_d   = '0;
        end else begin
          drain_d = d_cl + DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  // Line store: one bit per column of the previous row
  thd_ram #(
    .WIDTH (1),
    .DEPTH (thd_pkg::MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ctl.bit_in),
    .rdata_o (ram_rdata)
  );

  // Hand item flags down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s2_q <= accept ? ctl : '0;
      s3_q <= s2_q;
    end
  end

  // Hold the drained bit for the output stage
  always_ff @(posedge clk_i) begin
    s3_bit_q <= ram_rdata;
  end

  // Stage 2: shift the window column chain, clear it at the end of an image
  assign cell_ctrl.shift = s2_q.pix;
  assign cell_ctrl.clear = s2_q.eoi;
  assign cell0_in.top    = ram_rdata;
  assign cell0_in.bot    = s2_q.bit_in;

  thd_col_cell u_cell_cur (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cell_ctrl),
    .bits_i (cell0_in),
    .bits_o (cur_col)
  );

  thd_col_cell u_cell_prev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cell_ctrl),
    .bits_i (cur_col),
    .bits_o (prev_col)
  );

  // Stage 3: form the result beats
  always_comb begin
    win_bit = dil_q ? (prev_col.top | prev_col.bot | cur_col.top | cur_col.bot)
                    : prev_col.top;
    push        = '0;
    res0        = '0;
    res1.pixel  = cur_col.top ? thd_pkg::PIX_SET : thd_pkg::PIX_CLEAR;
    res1.eoi    = 1'b0;
    if (s3_q.drain) begin
      push.first = 1'b1;
      res0.pixel = s3_bit_q ? thd_pkg::PIX_SET : thd_pkg::PIX_CLEAR;
      res0.eoi   = s3_q.eoi;
    end else if (s3_q.emit_win) begin
      push.first  = 1'b1;
      push.second = s3_q.emit_last;
      res0.pixel  = win_bit ? thd_pkg::PIX_SET : thd_pkg::PIX_CLEAR;
    end else if (s3_q.emit_last) begin
      push.first = 1'b1;
      res0       = res1;
    end
  end

  thd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (res0),
    .data1_i (res1),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_out),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata = res_out.pixel;
  assign m_axis_tlast = res_out.eoi;

  // Take a beat only if the queue has room for everything in flight plus two
  always_comb begin
    n_s2 = SW'(s2_q.emit_win) + SW'(s2_q.emit_last) + SW'(s2_q.drain);
    n_s3 = SW'(s3_q.emit_win) + SW'(s3_q.emit_last) + SW'(s3_q.drain);
    load = SW'(fifo_cnt) + n_s2 + n_s3;
    s_axis_tready = (load <= SW'(thd_pkg::FIFO_DEPTH - 2));
  end

endmodule

`default_nettype wire

@@ sv/thd_checker.sv @@
// Port-level checks of the threshold and 2x2 dilation unit, bound to the top.
`default_nettype none

module thd_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             cfg_valid_i,
  input wire logic                             cfg_ready_o,
  input wire logic [thd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input wire logic [thd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [thd_pkg::PIX_W-1:0]        s_axis_tdata,
  input wire logic                             s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [thd_pkg::PIX_W-1:0]        m_axis_tdata,
  input wire logic                             m_axis_tlast
);

  logic in_beat;
  logic quiet;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign quiet   = !m_axis_tvalid && !in_beat;

  // Output pixels are always fully clear or fully set
  a_binary_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == thd_pkg::PIX_CLEAR ||
                       m_axis_tdata == thd_pkg::PIX_SET))
    else $error("output pixel is neither clear nor set");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

  // With nothing in flight and nothing queued, the input side is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quiet ##1 quiet ##1 quiet |-> s_axis_tready)
    else $error("input stalled while the unit is empty");

  // Configuration writes are never held off; checked while no input beat is taken and no output is valid
  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && !in_beat && !m_axis_tvalid) |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind threshold_dilate_2x2_unit thd_checker u_thd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for the threshold and 2x2 dilation unit with a line-buffer predictor.
`timescale 1ns / 1ps

module testbench;
  import thd_pkg::*;

  localparam int LIMIT_CYCLES  = 800_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 480;
  localparam int MAX_SHOWN     = 30;

  // Predict binarized and dilated pixels, and hold the pixel beats still owed by the unit
  class dilate_scoreboard;
    logic [PIX_W-1:0]     thresh_q;
    logic [CFG_DIM_W-1:0] width_q;
    logic [CFG_DIM_W-1:0] height_q;
    logic                 dilate_q;
    logic                 line_bits [MAX_WIDTH];
    bit                   line_valid [MAX_WIDTH];
    logic                 win_top;
    logic                 win_bot;
    logic [DIM_W-1:0]     col_cnt;
    logic [DIM_W-1:0]     row_cnt;
    logic [DIM_W-1:0]     drain_cnt;
    result_t              want_q [$];
    int                   errors;
    int                   shown;
    int                   checked;

    function new();
      thresh_q  = THRESHOLD_RST;
      width_q   = WIDTH_RST;
      height_q  = HEIGHT_RST;
      dilate_q  = DILATE_RST;
      foreach (line_bits[i]) begin
        line_bits[i]  = 1'b0;
        line_valid[i] = 1'b0;
      end
      win_top   = 1'b0;
      win_bot   = 1'b0;
      col_cnt   = '0;
      row_cnt   = '0;
      drain_cnt = '0;
      errors    = 0;
      shown     = 0;
      checked   = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_THRESHOLD:    thresh_q = val[PIX_W-1:0];
        REG_IMAGE_WIDTH:  width_q  = val[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_q = val[CFG_DIM_W-1:0];
        default:          dilate_q = val[0];
      endcase
    endfunction

    // Clamp geometry: zero acts as one, oversize acts as the maximum
    function int eff_width();
      if (width_q == 0) return 1;
      if (width_q > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_q);
    endfunction

    function int eff_height();
      if (height_q == 0) return 1;
      if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_q);
    endfunction

    // All pixels of the image are in, counting a pending row wrap
    function bit image_full();
      int r;
      r = row_cnt;
      if (col_cnt >= eff_width() && row_cnt < eff_height()) r++;
      return r >= eff_height();
    endfunction

    function bit at_start();
      return col_cnt == 0 && row_cnt == 0 && drain_cnt == 0;
    endfunction

    function bit lines_ready(int n);
      for (int i = 0; i < n; i++) if (!line_valid[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void push(logic lit, logic eoi);
      result_t r;
      r.pixel = lit ? PIX_SET : PIX_CLEAR;
      r.eoi   = eoi;
      want_q.push_back(r);
    endfunction

    // Advance the line buffer and window by one accepted input beat
    function void note_beat(op_e op, logic [PIX_W-1:0] pix);
      int   w;
      int   h;
      int   c;
      int   r;
      int   d;
      logic b;
      logic top;
      logic v;
      w = eff_width();
      h = eff_height();
      // wrap a column count left beyond a narrowed row
      if (col_cnt >= w) begin
        col_cnt = '0;
        if (row_cnt < h) row_cnt++;
      end
      if (op == OP_PIXEL) begin
        c = col_cnt;
        r = row_cnt;
        if (r >= h || c >= MAX_WIDTH) return;
        b   = (pix >= thresh_q);
        top = line_bits[c];
        line_bits[c]  = b;
        line_valid[c] = 1'b1;
        if (r >= 1) begin
          if (c >= 1) begin
            v = dilate_q ? (win_top | win_bot | top | b) : win_top;
            push(v, 1'b0);
          end
          // last column of the upper row is only binarized
          if (c == w - 1) push(top, 1'b0);
        end
        win_top = top;
        win_bot = b;
        col_cnt++;
        if (col_cnt >= w) begin
          col_cnt = '0;
          row_cnt++;
        end
      end else begin
        d = drain_cnt;
        if (row_cnt < h) return;
        if (d >= MAX_WIDTH) d = MAX_WIDTH - 1;
        if (d >= w - 1) begin
          push(line_bits[d], 1'b1);
          drain_cnt = '0;
          col_cnt   = '0;
          row_cnt   = '0;
          win_top   = 1'b0;
          win_bot   = 1'b0;
        end else begin
          push(line_bits[d], 1'b0);
          drain_cnt = DIM_W'(d + 1);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (shown < MAX_SHOWN) begin
        shown++;
        $display("MISMATCH: %s", msg);
      end
    endtask

    // Compare one output beat with the oldest owed pixel
    task check_beat(logic [PIX_W-1:0] pix, logic last);
      result_t head;
      checked++;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected beat pixel=%0d last=%0b", pix, last));
        return;
      end
      head = want_q.pop_front();
      if (pix !== head.pixel)
        report($sformatf("beat %0d pixel %0d, want %0d", checked, pix, head.pixel));
      if (last !== head.eoi)
        report($sformatf("beat %0d last %0b, want %0b", checked, last, head.eoi));
    endtask
  endclass

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel  = '0;
  logic                  in_op     = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_pixel;
  logic                  out_last;

  dilate_scoreboard sb = new();
  bit  no_idle  = 1'b0;
  bit  hold_req = 1'b0;
  int  items    = 0;
  int  dropped  = 0;
  int  images   = 0;
  int  retunes  = 0;
  int  cycles   = 0;

  threshold_dilate_2x2_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_pixel),
    .s_axis_tuser  (in_op),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_pixel),
    .m_axis_tlast  (out_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check every output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_beat(out_pixel, out_last);
  end

  // Drive output backpressure: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Stop a hung run
  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one input beat, with an optional idle burst first
  task automatic send_beat(op_e op, logic [PIX_W-1:0] pix);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_pixel <= pix;
    do @(posedge clk_i); while (!in_ready);
    sb.note_beat(op, pix);
  endtask

  // Drain all owed results, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
  endtask

  task automatic shape(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] w,
                       logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] dil);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_DILATE_ENABLE, dil);
    end_cfg();
  endtask

  // Pick a grey value, biased toward the threshold edge
  function automatic logic [PIX_W-1:0] pick_pixel(int density);
    int t;
    t = sb.thresh_q;
    if ($urandom_range(0, 15) == 0)
      return (t > 0 && $urandom_range(0, 1) == 1) ? PIX_W'(t - 1) : PIX_W'(t);
    if (t == 0 || $urandom_range(0, 99) < density) return PIX_W'($urandom_range(t, 255));
    return PIX_W'($urandom_range(0, t - 1));
  endfunction

  // Change one register in the middle of an image
  task automatic retune();
    cfg_reg_e idx;
    int       cur_w;
    int       new_w;
    settle();
    idx = cfg_reg_e'($urandom_range(0, 3));
    case (idx)
      REG_THRESHOLD: write_reg(idx, CFG_DATA_W'($urandom));
      REG_IMAGE_WIDTH: begin
        new_w = $urandom_range(1, 16);
        cur_w = sb.eff_width();
        // skip a width that would read line entries never written
        if (sb.lines_ready(new_w > cur_w ? new_w : cur_w))
          write_reg(idx, CFG_DATA_W'(new_w));
      end
      REG_IMAGE_HEIGHT: write_reg(idx, CFG_DATA_W'($urandom_range(1, 6)));
      default: write_reg(idx, CFG_DATA_W'(!sb.dilate_q));
    endcase
    end_cfg();
    retunes++;
  endtask

  // Random geometry and settings for the next image
  task automatic new_shape();
    int pick;
    settle();
    if ($urandom_range(0, 1) == 1) begin
      pick = $urandom_range(0, 3);
      write_reg(REG_THRESHOLD, {2'($urandom), pick == 0 ? 8'd0 : pick == 1 ? 8'd255 :
                                8'($urandom)});
    end
    if ($urandom_range(0, 1) == 1)
      write_reg(REG_IMAGE_WIDTH,
                $urandom_range(0, 9) == 0 ? '0 : CFG_DATA_W'($urandom_range(1, 16)));
    if ($urandom_range(0, 1) == 1)
      write_reg(REG_IMAGE_HEIGHT,
                $urandom_range(0, 9) == 0 ? '0 : CFG_DATA_W'($urandom_range(1, 6)));
    if ($urandom_range(0, 1) == 1)
      write_reg(REG_DILATE_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
    end_cfg();
  endtask

  // Stream one whole image and its drain, with stray beats mixed in
  task automatic run_image(int density, bit retune_ok);
    do begin
      if (retune_ok && $urandom_range(0, 119) == 0) retune();
      if ($urandom_range(0, 29) == 0) begin
        send_beat(sb.image_full() ? OP_PIXEL : OP_DRAIN, PIX_W'($urandom));
        dropped++;
      end
      if (sb.image_full()) send_beat(OP_DRAIN, PIX_W'($urandom));
      else send_beat(OP_PIXEL, pick_pixel(density));
      items++;
    end while (!sb.at_start());
    images++;
  endtask

  initial begin
    int n_img;
    n_img = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 3x2 image at the threshold edge, with an early drain and a late pixel
    shape(10'h364, 10'd3, 10'd2, 10'd1);
    send_beat(OP_PIXEL, 8'd99);
    send_beat(OP_PIXEL, 8'd100);
    send_beat(OP_DRAIN, 8'hFF);
    send_beat(OP_PIXEL, 8'd255);
    send_beat(OP_PIXEL, 8'd0);
    send_beat(OP_PIXEL, 8'd101);
    send_beat(OP_PIXEL, 8'd99);
    send_beat(OP_PIXEL, 8'd200);
    repeat (3) send_beat(OP_DRAIN, 8'h00);

    // single row, height zero, threshold at top, no dilation
    shape(10'h0FF, 10'd4, 10'd0, 10'd0);
    send_beat(OP_PIXEL, 8'd255);
    send_beat(OP_PIXEL, 8'd254);
    send_beat(OP_PIXEL, 8'd0);
    send_beat(OP_PIXEL, 8'd255);
    repeat (4) send_beat(OP_DRAIN, 8'hAA);

    // single column, width zero, threshold zero
    shape(10'h300, 10'd0, 10'd3, 10'd1);
    send_beat(OP_PIXEL, 8'd0);
    send_beat(OP_PIXEL, 8'd128);
    send_beat(OP_PIXEL, 8'd7);
    send_beat(OP_DRAIN, 8'h55);

    // random images; one runs under a long output hold-off
    while (items < RANDOM_ITEMS) begin
      if (n_img == 3) begin
        settle();
        write_reg(REG_IMAGE_WIDTH, 10'd16);
        write_reg(REG_IMAGE_HEIGHT, 10'd5);
        end_cfg();
        hold_req = 1'b1;
        run_image(50, 1'b0);
      end else begin
        new_shape();
        run_image($urandom_range(0, 100), 1'b1);
      end
      n_img++;
      if (items > RANDOM_ITEMS * 85 / 100) no_idle = 1'b1;
    end

    // full-height single column, oversize height clamped to the maximum
    no_idle = 1'b1;
    shape(10'h3C0, 10'd0, 10'd1023, 10'd0);
    run_image(70, 1'b0);
    settle();

    $display("summary: %0d images, %0d image beats, %0d stray beats, %0d retunes",
             images, items, dropped, retunes);
    $display("summary: %0d output beats checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
